[rtl/core/bsp_pkg.sv]
// shared types and constants of the bencode stream parser
package bsp_pkg;

    localparam int MAX_NEST    = 32;
    localparam int LENGTH_BITS = 20;
    localparam int DEPTH_W     = $clog2(MAX_NEST + 1);
    localparam int ADDR_W      = $clog2(MAX_NEST);
    localparam int CFG_W       = 6;
    localparam int LIM_W       = (DEPTH_W > CFG_W) ? DEPTH_W : CFG_W;
    localparam int TDATA_W     = 24;
    localparam int TUSER_W     = 4;

    localparam logic [CFG_W-1:0] MAX_DEPTH_RESET = 6'd32;

    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_E     = 8'h65;
    localparam logic [7:0] CH_I     = 8'h69;
    localparam logic [7:0] CH_L     = 8'h6c;
    localparam logic [7:0] CH_D     = 8'h64;
    localparam logic [7:0] CH_DEL   = 8'h7f;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [1:0] {
        MODE_VALUE,
        MODE_LEN,
        MODE_STR,
        MODE_INT
    } mode_t;

    typedef enum logic [3:0] {
        EV_SKIP      = 4'd0,
        EV_LEN_DIGIT = 4'd1,
        EV_COLON     = 4'd2,
        EV_STR_BYTE  = 4'd3,
        EV_INT_OPEN  = 4'd4,
        EV_INT_DIGIT = 4'd5,
        EV_OPEN      = 4'd6,
        EV_CLOSE     = 4'd7,
        EV_END       = 4'd8
    } event_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_BAD_BYTE  = 3'd1,
        ERR_LEN_OVF   = 3'd2,
        ERR_TOO_DEEP  = 3'd3,
        ERR_NO_VALUE  = 3'd4,
        ERR_EARLY_END = 3'd5
    } err_t;

    typedef struct packed {
        logic is_dict;
        logic expect_key;
    } stack_entry_t;

    // first member sits in the high bits, so byte_value lands at bit 0
    typedef struct packed {
        logic [2:0] error_code;
        logic       error_flag;
        logic       value_complete;
        logic       is_control;
        logic       utf8_valid;
        logic       string_last;
        logic       in_key;
        logic       container_is_dict;
        logic [5:0] nest_depth;
        logic [7:0] byte_value;
    } payload_t;

    typedef struct packed {
        event_t   event_kind;
        payload_t payload;
    } result_t;

endpackage

[rtl/core/bencode_stream_parser.sv]
// bencode stream parser: tags each byte of a bencoded stream
//
// channel  | dir | request                                   | handshake
// ---------+-----+-------------------------------------------+-------------------
// s_       | in  | tdata[7:0] data_byte                      | tvalid / tready
// m_       | out | tuser event_kind, tdata tagged byte flags | tvalid / tready
// cfg_     | in  | wr_data max_depth_in_use                  | wr_en, no wait
//
// one byte a cycle while s_tready is high, one result per byte; the stack
// memory read runs one entry below the top each cycle
// the top of the nesting stack lives in flops, the entries below it in a
// MAX_NEST x 2 bit synchronous memory; the read port prefetches the entry
// below the top, with forwarding when a push writes that same entry
// rst_n clears the parse state, depth, errors and the depth limit (to 32)
// a two-deep output stage lets a new byte in while a result waits
module bencode_stream_parser (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] data_byte
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // [7:0] byte_value, [13:8] nest_depth, [14] container_is_dict, [15] in_key,
    // [16] string_last, [17] utf8_valid, [18] is_control, [19] value_complete,
    // [20] error_flag, [23:21] error_code
    output logic [bsp_pkg::TDATA_W-1:0]  m_tdata,
    output logic [bsp_pkg::TUSER_W-1:0]  m_tuser,   // [3:0] event_kind
    input  logic                         cfg_wr_en,
    input  logic [bsp_pkg::CFG_W-1:0]    cfg_wr_data  // max_depth_in_use
);
    import bsp_pkg::*;

    // parse state
    mode_t                  mode_reg, mode_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [1:0]             pend_reg, pend_next;
    logic                   bad_reg, bad_next;
    logic [DEPTH_W-1:0]     depth_reg, depth_next;
    err_t                   err_reg, err_next;
    stack_entry_t           top_reg, top_next;
    logic [CFG_W-1:0]       max_depth_reg;

    // stack memory and its registered read data (the entry below the top)
    stack_entry_t           stack_mem [MAX_NEST];
    stack_entry_t           below_reg;
    logic                   push;
    logic [ADDR_W-1:0]      wr_addr;
    logic [ADDR_W-1:0]      rd_addr;

    // output stage
    result_t                out_reg, skid_reg;
    logic                   out_valid_reg, skid_valid_reg;
    result_t                res;

    logic                   accept;
    logic                   take;

    // combinational helpers
    logic                   is_digit;
    logic [3:0]             digit;
    logic [LENGTH_BITS+3:0] len_ext;
    logic [LENGTH_BITS+3:0] len_x10;
    logic                   len_ovf;
    logic                   top_dict;
    logic                   at_key;
    logic [LIM_W-1:0]       limit;
    logic [LIM_W-1:0]       cfg_ext;
    logic [LIM_W-1:0]       depth_ext;
    logic                   str_done;
    logic                   utf_bad_now;
    logic [1:0]             utf_pend_now;
    err_t                   err_new;
    event_t                 ev;
    logic                   o_dict, o_key, o_last, o_utf, o_ctrl, o_vc;

    assign accept   = s_tvalid && s_tready;
    assign take     = m_tvalid && m_tready;
    assign s_tready = !skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'(out_reg.payload);
    assign m_tuser  = TUSER_W'(out_reg.event_kind);

    // depth limit clamped to 1..MAX_NEST
    always_comb
    begin
        cfg_ext = LIM_W'(max_depth_reg);
        if (cfg_ext == '0)
            limit = LIM_W'(1);
        else if (cfg_ext > LIM_W'(MAX_NEST))
            limit = LIM_W'(MAX_NEST);
        else
            limit = cfg_ext;
    end

    assign depth_ext = LIM_W'(depth_reg);
    assign is_digit  = (s_tdata >= CH_ZERO) && (s_tdata <= CH_NINE);
    assign digit     = 4'(s_tdata - CH_ZERO);
    assign top_dict  = (depth_reg != '0) && top_reg.is_dict;
    assign at_key    = top_dict && top_reg.expect_key;

    // length times ten plus the new digit
    assign len_ext = (LENGTH_BITS+4)'(len_reg);
    assign len_x10 = (len_ext << 3) + (len_ext << 1) + (LENGTH_BITS+4)'(digit);
    assign len_ovf = |len_x10[LENGTH_BITS+3:LENGTH_BITS];

    // utf-8 tracking of one string byte
    always_comb
    begin
        utf_bad_now  = bad_reg;
        utf_pend_now = pend_reg;
        if (!bad_reg)
        begin
            if (pend_reg == 2'd0)
            begin
                if (!s_tdata[7])
                    utf_pend_now = 2'd0;
                else if (s_tdata[7:4] == 4'hf)
                    utf_pend_now = 2'd3;
                else if (s_tdata[7:4] == 4'he)
                    utf_pend_now = 2'd2;
                else if (s_tdata[7:5] == 3'b110)
                    utf_pend_now = 2'd1;
                else
                    utf_bad_now = 1'b1;
            end
            else if (s_tdata[7:6] == 2'b10)
                utf_pend_now = pend_reg - 2'd1;
            else
                utf_bad_now = 1'b1;
            if (utf_bad_now)
                utf_pend_now = 2'd0;
        end
    end

    assign str_done = (len_reg == LENGTH_BITS'(1));

    // next-state and result of one byte
    always_comb
    begin
        mode_next  = mode_reg;
        len_next   = len_reg;
        pend_next  = pend_reg;
        bad_next   = bad_reg;
        depth_next = depth_reg;
        top_next   = top_reg;
        err_new    = ERR_NONE;
        push       = 1'b0;
        ev         = EV_SKIP;
        o_dict     = 1'b0;
        o_key      = 1'b0;
        o_last     = 1'b0;
        o_utf      = 1'b0;
        o_ctrl     = 1'b0;
        o_vc       = 1'b0;

        if (err_reg == ERR_NONE)
        begin
            case (mode_reg)
                MODE_VALUE:
                begin
                    if (s_tdata == CH_NL)
                        ev = EV_SKIP;
                    else if (is_digit)
                    begin
                        ev        = EV_LEN_DIGIT;
                        o_key     = at_key;
                        len_next  = LENGTH_BITS'(digit);
                        mode_next = MODE_LEN;
                    end
                    else if (s_tdata == 8'h00)
                    begin
                        if (depth_reg != '0)
                            err_new = ERR_EARLY_END;
                        else
                            ev = EV_END;
                    end
                    else if (s_tdata == CH_E)
                    begin
                        if (depth_reg == '0)
                            err_new = ERR_BAD_BYTE;
                        else if (top_dict && !top_reg.expect_key)
                            err_new = ERR_NO_VALUE;
                        else
                        begin
                            // pop: the entry below becomes the top, the closed
                            // container counts as a finished value there
                            ev         = EV_CLOSE;
                            o_dict     = top_dict;
                            depth_next = depth_reg - DEPTH_W'(1);
                            top_next   = below_reg;
                            if (depth_next == '0)
                                o_vc = 1'b1;
                            else if (below_reg.is_dict)
                                top_next.expect_key = !below_reg.expect_key;
                        end
                    end
                    else if (at_key)
                        err_new = ERR_BAD_BYTE;
                    else if (s_tdata == CH_I)
                    begin
                        ev        = EV_INT_OPEN;
                        mode_next = MODE_INT;
                    end
                    else if (s_tdata == CH_L || s_tdata == CH_D)
                    begin
                        if (depth_ext >= limit)
                            err_new = ERR_TOO_DEEP;
                        else
                        begin
                            ev                  = EV_OPEN;
                            o_dict              = (s_tdata == CH_D);
                            push                = (depth_reg != '0);
                            top_next.is_dict    = (s_tdata == CH_D);
                            top_next.expect_key = 1'b1;
                            depth_next          = depth_reg + DEPTH_W'(1);
                        end
                    end
                    else
                        err_new = ERR_BAD_BYTE;
                end
                MODE_LEN:
                begin
                    if (is_digit)
                    begin
                        if (len_ovf)
                            err_new = ERR_LEN_OVF;
                        else
                        begin
                            len_next = len_x10[LENGTH_BITS-1:0];
                            ev       = EV_LEN_DIGIT;
                            o_key    = at_key;
                        end
                    end
                    else if (s_tdata == CH_COLON)
                    begin
                        ev        = EV_COLON;
                        o_key     = at_key;
                        pend_next = 2'd0;
                        bad_next  = 1'b0;
                        if (len_reg == '0)
                        begin
                            // empty string ends on its colon
                            o_last    = 1'b1;
                            o_utf     = 1'b1;
                            mode_next = MODE_VALUE;
                            if (depth_reg == '0)
                                o_vc = 1'b1;
                            else if (top_dict)
                                top_next.expect_key = !top_reg.expect_key;
                        end
                        else
                            mode_next = MODE_STR;
                    end
                    else if (s_tdata == 8'h00)
                        err_new = ERR_EARLY_END;
                    else
                        err_new = ERR_BAD_BYTE;
                end
                MODE_STR:
                begin
                    ev        = EV_STR_BYTE;
                    o_key     = at_key;
                    o_ctrl    = (s_tdata < CH_SPACE) || (s_tdata == CH_DEL);
                    pend_next = utf_pend_now;
                    bad_next  = utf_bad_now;
                    len_next  = len_reg - LENGTH_BITS'(1);
                    if (str_done)
                    begin
                        o_last    = 1'b1;
                        o_utf     = !utf_bad_now && (utf_pend_now == 2'd0);
                        mode_next = MODE_VALUE;
                        if (depth_reg == '0)
                            o_vc = 1'b1;
                        else if (top_dict)
                            top_next.expect_key = !top_reg.expect_key;
                    end
                end
                MODE_INT:
                begin
                    if (is_digit)
                        ev = EV_INT_DIGIT;
                    else if (s_tdata == CH_E)
                    begin
                        ev        = EV_INT_DIGIT;
                        mode_next = MODE_VALUE;
                        if (depth_reg == '0)
                            o_vc = 1'b1;
                        else if (top_dict)
                            top_next.expect_key = !top_reg.expect_key;
                    end
                    else if (s_tdata == 8'h00)
                        err_new = ERR_EARLY_END;
                    else
                        err_new = ERR_BAD_BYTE;
                end
                default:
                    mode_next = MODE_VALUE;
            endcase

            // an error freezes the parse state
            if (err_new != ERR_NONE)
            begin
                mode_next  = mode_reg;
                len_next   = len_reg;
                pend_next  = pend_reg;
                bad_next   = bad_reg;
                depth_next = depth_reg;
                top_next   = top_reg;
                push       = 1'b0;
            end
        end

        err_next = (err_reg != ERR_NONE) ? err_reg : err_new;

        res                            = '0;
        res.payload.byte_value         = s_tdata;
        res.payload.nest_depth         = 6'(depth_next);
        if (err_next != ERR_NONE)
        begin
            res.event_kind             = EV_SKIP;
            res.payload.error_flag     = 1'b1;
            res.payload.error_code     = err_next;
        end
        else
        begin
            res.event_kind                = ev;
            res.payload.container_is_dict = o_dict;
            res.payload.in_key            = o_key;
            res.payload.string_last       = o_last;
            res.payload.utf8_valid        = o_utf;
            res.payload.is_control        = o_ctrl;
            res.payload.value_complete    = o_vc;
        end
    end

    // a push stores the old top just below the new one
    assign wr_addr = ADDR_W'(depth_reg - DEPTH_W'(1));
    // keep the entry below the top ready for the next pop
    assign rd_addr = accept ? ADDR_W'(depth_next - DEPTH_W'(2))
                            : ADDR_W'(depth_reg - DEPTH_W'(2));

    always_ff @(posedge clk)
    begin
        if (accept && push)
            stack_mem[wr_addr] <= top_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept && push && (rd_addr == wr_addr))
            below_reg <= top_reg;
        else
            below_reg <= stack_mem[rd_addr];
    end

    // parse state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_VALUE;
            len_reg   <= '0;
            pend_reg  <= 2'd0;
            bad_reg   <= 1'b0;
            depth_reg <= '0;
            err_reg   <= ERR_NONE;
            top_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            len_reg   <= len_next;
            pend_reg  <= pend_next;
            bad_reg   <= bad_next;
            depth_reg <= depth_next;
            err_reg   <= err_next;
            top_reg   <= top_next;
        end
    end

    // depth limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_depth_reg <= MAX_DEPTH_RESET;
        else if (cfg_wr_en)
            max_depth_reg <= cfg_wr_data;
    end

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (take || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (take || !out_valid_reg)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else if (accept)
                out_reg <= res;
        end
        else if (accept)
            skid_reg <= res;
    end

`ifndef SYNTHESIS
    // depth never passes the stack size
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(MAX_NEST))
        else $error("nesting depth beyond stack size");

    // an error stays until reset
    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg != ERR_NONE) |=> (err_reg == $past(err_reg)))
        else $error("sticky error changed");

    // string data mode always has bytes left
    a_str_len: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_STR) |-> (len_reg != '0))
        else $error("string mode with zero length left");

    // skid entry only fills behind a waiting result
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    // depth moves by at most one per byte
    a_depth_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (depth_reg == $past(depth_reg)
                    || depth_reg == $past(depth_reg) + DEPTH_W'(1)
                    || depth_reg == $past(depth_reg) - DEPTH_W'(1)))
        else $error("depth jumped");
`endif

endmodule
